### design/srlrd_pkg.sv
// ----------------------------------------------------------------------------
// srlrd_pkg: shared types and constants of the serial receive ring
// Holds the ring geometry, the index step function, the result kinds and the
// command record that travels from the front part to the back part.
// ----------------------------------------------------------------------------
`default_nettype none

package srlrd_pkg;

    // Ring geometry. Slot 0 is never used; indices run from BUFFER_SIZE-1 down to 1.
    localparam int BUFFER_SIZE = 64;
    localparam int IDX_W       = $clog2(BUFFER_SIZE);

    // Depth of the command queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Character constants.
    localparam logic [6:0] CHAR_MASK = 7'h7F;
    localparam logic [6:0] CH_NUL    = 7'd0;
    localparam logic [6:0] CH_NL     = 7'd10;
    localparam logic [6:0] CH_CR     = 7'd13;
    localparam logic [6:0] CH_SEMI   = 7'd59;

    // Input opcodes.
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } opcode_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_ECHO = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    // Configuration register indices.
    typedef enum logic [1:0] {
        REG_ECHO_ENABLE     = 2'd0,
        REG_CRLF_EXPAND     = 2'd1,
        REG_LINE_MODE       = 2'd2,
        REG_SEMICOLON_BREAK = 2'd3
    } reg_index_t;

    // Phase of the back part within one command.
    typedef enum logic [1:0] {
        BK_CHAR  = 2'd0,
        BK_CR    = 2'd1,
        BK_FINAL = 2'd2
    } back_state_t;

    // Configuration bits as seen by the back part.
    typedef struct packed {
        logic echo_enable;
        logic crlf_expand;
        logic line_mode;
        logic semicolon_break;
    } cfg_t;

    // One classified command. For a push, flag means the byte was dropped;
    // for a read, flag means the buffer was empty.
    typedef struct packed {
        logic       is_read;
        logic       flag;
        logic [6:0] data;
    } cmd_t;

    // One step down the ring with wrap, skipping slot 0.
    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if ((idx <= IDX_W'(1)) || (idx > IDX_W'(BUFFER_SIZE - 1))) begin
            res = IDX_W'(BUFFER_SIZE - 1);
        end else begin
            res = idx - IDX_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### design/srlrd_front.sv
// ----------------------------------------------------------------------------
// srlrd_front: input side of the serial receive ring
// Accepts push and read requests, keeps the ring indices and the character
// memory, and hands one classified command per request to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module srlrd_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 in_opcode,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 q_ready,
    output logic                      q_push,
    output srlrd_pkg::cmd_t           q_cmd
);

    logic [7:0]                  mem [srlrd_pkg::BUFFER_SIZE];
    logic [srlrd_pkg::IDX_W-1:0] write_index_reg, write_index_next;
    logic [srlrd_pkg::IDX_W-1:0] read_index_reg,  read_index_next;
    logic                        stage_valid_reg, stage_valid_next;
    logic                        stage_read_reg,  stage_read_next;
    logic                        stage_flag_reg,  stage_flag_next;
    logic [7:0]                  rdata_reg;
    logic                        accept;
    logic                        is_read;
    logic                        is_empty;
    logic                        is_full;
    logic                        do_write;
    logic                        do_read;
    logic [srlrd_pkg::IDX_W-1:0] write_step;
    logic [srlrd_pkg::IDX_W-1:0] read_step;

    assign in_ready   = !stage_valid_reg || q_ready;
    assign accept     = in_valid && in_ready;
    assign is_read    = (in_opcode == srlrd_pkg::OP_READ);
    assign write_step = srlrd_pkg::step_down(write_index_reg);
    assign read_step  = srlrd_pkg::step_down(read_index_reg);
    assign is_full    = (write_step == read_index_reg);
    assign is_empty   = (write_index_reg == read_index_reg);
    assign do_write   = accept && !is_read && !is_full;
    assign do_read    = accept && is_read && !is_empty;

    assign q_push       = stage_valid_reg && q_ready;
    assign q_cmd.is_read = stage_read_reg;
    assign q_cmd.flag    = stage_flag_reg;
    assign q_cmd.data    = stage_read_reg ? (rdata_reg[6:0] & srlrd_pkg::CHAR_MASK) : 7'd0;

    always_comb begin
        write_index_next = do_write ? write_step : write_index_reg;
        read_index_next  = do_read  ? read_step  : read_index_reg;
        stage_valid_next = stage_valid_reg;
        stage_read_next  = stage_read_reg;
        stage_flag_next  = stage_flag_reg;
        if (accept) begin
            stage_valid_next = 1'b1;
            stage_read_next  = is_read;
            stage_flag_next  = is_read ? is_empty : is_full;
        end else if (q_push) begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_index_reg <= srlrd_pkg::IDX_W'(1);
            read_index_reg  <= srlrd_pkg::IDX_W'(1);
            stage_valid_reg <= 1'b0;
        end else begin
            write_index_reg <= write_index_next;
            read_index_reg  <= read_index_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stage_read_reg <= stage_read_next;
        stage_flag_reg <= stage_flag_next;
    end

    // Character memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[write_step] <= in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_read) begin
            rdata_reg <= mem[read_step];
        end
    end

    ap_index_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (write_index_reg != '0) && (read_index_reg != '0))
        else $error("ring index reached the unused slot");

    ap_push_order: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_valid_reg && !q_ready |=> stage_valid_reg && $stable(stage_read_reg)
            && $stable(stage_flag_reg))
        else $error("staged command changed while the queue was full");

    ap_write_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        do_write |=> (write_index_reg != read_index_reg))
        else $error("a stored byte left the ring looking empty");

endmodule

`default_nettype wire

### design/srlrd_queue.sv
// ----------------------------------------------------------------------------
// srlrd_queue: command queue between front and back
// A short first-in first-out store of classified commands, so that either
// side can stall without holding up the other.
// ----------------------------------------------------------------------------
`default_nettype none

module srlrd_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire srlrd_pkg::cmd_t  push_cmd,
    output logic                  push_ready,
    input  wire logic             pop,
    output logic                  head_valid,
    output srlrd_pkg::cmd_t       head_cmd
);

    srlrd_pkg::cmd_t                   entries [srlrd_pkg::QUEUE_DEPTH];
    logic [srlrd_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [srlrd_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [srlrd_pkg::QUEUE_CNT_W-1:0] count_reg,  count_next;
    logic                              do_push;
    logic                              do_pop;

    function automatic logic [srlrd_pkg::QUEUE_PTR_W-1:0] ptr_inc(
        input logic [srlrd_pkg::QUEUE_PTR_W-1:0] p);
        logic [srlrd_pkg::QUEUE_PTR_W-1:0] r;
        if (p == srlrd_pkg::QUEUE_PTR_W'(srlrd_pkg::QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + srlrd_pkg::QUEUE_PTR_W'(1);
        end
        return r;
    endfunction

    assign push_ready = (count_reg != srlrd_pkg::QUEUE_CNT_W'(srlrd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + srlrd_pkg::QUEUE_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - srlrd_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    ap_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= srlrd_pkg::QUEUE_CNT_W'(srlrd_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    ap_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with diverging pointers");

    ap_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop && !do_push && (count_reg == srlrd_pkg::QUEUE_CNT_W'(1)) |=> !head_valid)
        else $error("queue still valid after last pop");

endmodule

`default_nettype wire

### design/srlrd_back.sv
// ----------------------------------------------------------------------------
// srlrd_back: output side of the serial receive ring
// Takes one command at a time, applies the line translation and sends the
// echo characters and the final status or read result through a register.
// ----------------------------------------------------------------------------
`default_nettype none

module srlrd_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire srlrd_pkg::cfg_t  cfg,
    input  wire logic             cmd_valid,
    input  wire srlrd_pkg::cmd_t  cmd,
    output logic                  cmd_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [1:0]            out_kind,
    output logic [6:0]            out_char,
    output logic                  out_empty,
    output logic                  out_dropped,
    output logic                  out_last
);

    srlrd_pkg::back_state_t state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_kind_reg;
    logic [6:0]             out_char_reg;
    logic                   out_empty_reg;
    logic                   out_dropped_reg;
    logic                   out_last_reg;
    logic                   load;
    logic [6:0]             ch;
    logic                   echo_first;
    logic                   cr_needed;
    logic                   item_final;
    logic [1:0]             item_kind;
    logic [6:0]             item_char;
    logic                   item_empty;
    logic                   item_dropped;

    assign load = cmd_valid && (!out_valid_reg || out_ready);

    always_comb begin
        ch = cmd.data;
        if (cfg.line_mode && ((cmd.data == srlrd_pkg::CH_NUL)
            || (cfg.semicolon_break && (cmd.data == srlrd_pkg::CH_SEMI)))) begin
            ch = srlrd_pkg::CH_NL;
        end
    end

    assign echo_first = cmd.is_read && !cmd.flag && cfg.echo_enable;
    assign cr_needed  = echo_first && cfg.crlf_expand && (ch == srlrd_pkg::CH_NL);

    // Next phase.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srlrd_pkg::BK_CHAR: begin
                if (load && echo_first) begin
                    state_next = cr_needed ? srlrd_pkg::BK_CR : srlrd_pkg::BK_FINAL;
                end
            end
            srlrd_pkg::BK_CR: begin
                if (load) begin
                    state_next = srlrd_pkg::BK_FINAL;
                end
            end
            srlrd_pkg::BK_FINAL: begin
                if (load) begin
                    state_next = srlrd_pkg::BK_CHAR;
                end
            end
            default: begin
                state_next = srlrd_pkg::BK_CHAR;
            end
        endcase
    end

    // Item selected by the phase.
    always_comb begin
        item_final   = 1'b1;
        item_kind    = cmd.is_read ? srlrd_pkg::KIND_READ : srlrd_pkg::KIND_PUSH;
        item_char    = (cmd.is_read && !cmd.flag) ? ch : 7'd0;
        item_empty   = cmd.is_read && cmd.flag;
        item_dropped = !cmd.is_read && cmd.flag;
        case (state_reg)
            srlrd_pkg::BK_CHAR: begin
                if (echo_first) begin
                    item_final   = 1'b0;
                    item_kind    = srlrd_pkg::KIND_ECHO;
                    item_char    = ch;
                    item_empty   = 1'b0;
                    item_dropped = 1'b0;
                end
            end
            srlrd_pkg::BK_CR: begin
                item_final   = 1'b0;
                item_kind    = srlrd_pkg::KIND_ECHO;
                item_char    = srlrd_pkg::CH_CR;
                item_empty   = 1'b0;
                item_dropped = 1'b0;
            end
            srlrd_pkg::BK_FINAL: begin
                item_final = 1'b1;
            end
            default: begin
                item_final = 1'b1;
            end
        endcase
    end

    assign cmd_pop = load && item_final;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= srlrd_pkg::BK_CHAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_kind_reg    <= item_kind;
            out_char_reg    <= item_char;
            out_empty_reg   <= item_empty;
            out_dropped_reg <= item_dropped;
            out_last_reg    <= item_final;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_char    = out_char_reg;
    assign out_empty   = out_empty_reg;
    assign out_dropped = out_dropped_reg;
    assign out_last    = out_last_reg;

    ap_push_status: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_kind_reg == srlrd_pkg::KIND_PUSH)
            |-> out_last_reg && (out_char_reg == 7'd0) && !out_empty_reg)
        else $error("malformed push status");

    ap_echo_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_kind_reg == srlrd_pkg::KIND_ECHO)
            |-> !out_last_reg && !out_empty_reg && !out_dropped_reg)
        else $error("echo item marked as final");

    ap_empty_read: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_empty_reg
            |-> (out_kind_reg == srlrd_pkg::KIND_READ) && (out_char_reg == 7'd0))
        else $error("empty flag on a non-read item or with data");

    ap_cr_then_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == srlrd_pkg::BK_CR)
            |=> (state_reg == srlrd_pkg::BK_CR) || (state_reg == srlrd_pkg::BK_FINAL))
        else $error("carriage return phase not followed by the final item");

endmodule

`default_nettype wire

### design/serial_rx_ring_line_discipline.sv
// ----------------------------------------------------------------------------
// serial_rx_ring_line_discipline: receive ring buffer with line discipline
// Path: a request passes through the front's stage register, the command queue
// and the back's output register before its first result is valid on the m_ side.
// Results: a push gives one result item; a read gives one to three result items
// (echo, optional carriage return, read result) from the output sequencer.
// Reset (aresetn low, synchronous) sets both ring indices to 1, empties the queue
// and output register, and loads the registers with echo on, all else off.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_rx_ring_line_discipline (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Request stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  wire logic [0:0]  s_tuser,    // [0] opcode

    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // [6:0] out_char, [7] buffer_empty,
                                         // [8] byte_dropped, [15:9] zero
    output logic [1:0]       m_tuser,    // [1:0] kind
    output logic             m_tlast,    // last

    // Register port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // The four one-bit registers. A write lands on the access cycle of an APB
    // transfer; the register is picked by the word address, the byte offset bits
    // are ignored, and only bit 0 of the write data is kept.
    logic                   echo_enable_reg,     echo_enable_next;
    logic                   crlf_expand_reg,     crlf_expand_next;
    logic                   line_mode_reg,       line_mode_next;
    logic                   semicolon_break_reg, semicolon_break_next;
    logic                   cfg_write;
    srlrd_pkg::reg_index_t  cfg_sel;
    srlrd_pkg::cfg_t        cfg;

    // Front to queue, queue to back.
    logic                   q_push;
    logic                   q_ready;
    srlrd_pkg::cmd_t        q_in_cmd;
    logic                   q_pop;
    logic                   q_valid;
    srlrd_pkg::cmd_t        q_head_cmd;

    // Back outputs.
    logic [1:0]             out_kind;
    logic [6:0]             out_char;
    logic                   out_empty;
    logic                   out_dropped;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = srlrd_pkg::reg_index_t'(paddr[3:2]);

    always_comb begin
        echo_enable_next     = echo_enable_reg;
        crlf_expand_next     = crlf_expand_reg;
        line_mode_next       = line_mode_reg;
        semicolon_break_next = semicolon_break_reg;
        if (cfg_write) begin
            case (cfg_sel)
                srlrd_pkg::REG_ECHO_ENABLE:     echo_enable_next     = pwdata[0];
                srlrd_pkg::REG_CRLF_EXPAND:     crlf_expand_next     = pwdata[0];
                srlrd_pkg::REG_LINE_MODE:       line_mode_next       = pwdata[0];
                srlrd_pkg::REG_SEMICOLON_BREAK: semicolon_break_next = pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_enable_reg     <= 1'b1;
            crlf_expand_reg     <= 1'b0;
            line_mode_reg       <= 1'b0;
            semicolon_break_reg <= 1'b0;
        end else begin
            echo_enable_reg     <= echo_enable_next;
            crlf_expand_reg     <= crlf_expand_next;
            line_mode_reg       <= line_mode_next;
            semicolon_break_reg <= semicolon_break_next;
        end
    end

    // Register read back, zero-extended to the bus width.
    always_comb begin
        case (cfg_sel)
            srlrd_pkg::REG_ECHO_ENABLE:     prdata = {31'd0, echo_enable_reg};
            srlrd_pkg::REG_CRLF_EXPAND:     prdata = {31'd0, crlf_expand_reg};
            srlrd_pkg::REG_LINE_MODE:       prdata = {31'd0, line_mode_reg};
            srlrd_pkg::REG_SEMICOLON_BREAK: prdata = {31'd0, semicolon_break_reg};
            default:                        prdata = 32'd0;
        endcase
    end

    assign cfg.echo_enable     = echo_enable_reg;
    assign cfg.crlf_expand     = crlf_expand_reg;
    assign cfg.line_mode       = line_mode_reg;
    assign cfg.semicolon_break = semicolon_break_reg;

    // The front part owns the ring indices and the character memory. It settles
    // each request in the cycle it is accepted (store, drop, empty or fetch), so
    // the next request always sees up-to-date indices. The fetched byte lands in
    // the memory's read register alongside the staged command.
    srlrd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tuser[0]),
        .in_byte   (s_tdata),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_cmd     (q_in_cmd)
    );

    // The queue lets the front keep taking pushes while the back is still busy
    // sending the echo items of an earlier read.
    srlrd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_in_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head_cmd)
    );

    // The back part translates the character and sends one result item per cycle
    // unless m_tready stalls, via its output register; the last item pops the command.
    srlrd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .cmd_valid   (q_valid),
        .cmd         (q_head_cmd),
        .cmd_pop     (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (out_kind),
        .out_char    (out_char),
        .out_empty   (out_empty),
        .out_dropped (out_dropped),
        .out_last    (m_tlast)
    );

    assign m_tuser = out_kind;
    assign m_tdata = {7'd0, out_dropped, out_empty, out_char};

endmodule

`default_nettype wire
